// ===== hw/rtl/eso_pkg.sv =====
// ----------------------------------------------------------------------------
// eso_pkg: shared types and constants
// Payload types, register indexes and the saturating narrow for the observer.
// ----------------------------------------------------------------------------
package eso_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ACC_W     = 52;
	localparam int MRES_W    = 51;
	localparam int OPND_W    = 34;
	localparam int SQ_IN_W   = 50;
	localparam int SQ_OUT_W  = 25;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B0      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_G1      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_G2      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_G3      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ISC_H   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ISC_TQ  = 3'd6;

	typedef struct packed {
		logic signed [31:0] control_value;
		logic signed [31:0] measured_output;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] position_estimate;
		logic signed [31:0] rate_estimate;
		logic signed [31:0] disturbance_estimate;
	} estimate_t;

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(64'sd2147483647);
		lo = -ACC_W'(64'sd2147483648);
		if (v > hi)
			return 32'sh7FFF_FFFF;
		else if (v < lo)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

// ===== hw/rtl/eso_if.sv =====
// ----------------------------------------------------------------------------
// eso_if: valid/ready channels
// One interface for input samples, one for estimate beats.
// ----------------------------------------------------------------------------
interface eso_sample_if;
	logic             valid;
	logic             ready;
	eso_pkg::sample_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface eso_estimate_if;
	logic               valid;
	logic               ready;
	eso_pkg::estimate_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/eso_mul.sv =====
// ----------------------------------------------------------------------------
// eso_mul: shared Q16.16 multiplier
// Registered sign-magnitude product, rounded to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module eso_mul (
	input  logic                                clk,
	input  logic signed [eso_pkg::OPND_W-1:0]   a,
	input  logic signed [eso_pkg::OPND_W-1:0]   b,
	output logic signed [eso_pkg::MRES_W-1:0]   res
);
	import eso_pkg::*;

	logic [OPND_W-2:0]       mag_a;
	logic [OPND_W-2:0]       mag_b;
	logic [2*OPND_W-2:0]     prod_q;
	logic                    neg_q;
	logic [2*OPND_W-2:0]     rnd;

	assign mag_a = a[OPND_W-1] ? (OPND_W-1)'(-a) : a[OPND_W-2:0];
	assign mag_b = b[OPND_W-1] ? (OPND_W-1)'(-b) : b[OPND_W-2:0];

	always_ff @(posedge clk) begin
		prod_q <= (2*OPND_W-1)'(mag_a) * (2*OPND_W-1)'(mag_b);
		neg_q  <= a[OPND_W-1] ^ b[OPND_W-1];
	end

	assign rnd = (prod_q + (2*OPND_W-1)'(1 << (FRAC_BITS-1))) >> FRAC_BITS;
	assign res = neg_q ? -$signed({1'b0, rnd[MRES_W-2:0]})
	                   :  $signed({1'b0, rnd[MRES_W-2:0]});
endmodule

// ===== hw/rtl/eso_sqrt.sv =====
// ----------------------------------------------------------------------------
// eso_sqrt: integer square root
// Digit-recurrence floor root, one result bit per cycle.
// ----------------------------------------------------------------------------
module eso_sqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [eso_pkg::SQ_IN_W-1:0]         x,
	output logic                                done,
	output logic [eso_pkg::SQ_OUT_W-1:0]        root
);
	import eso_pkg::*;

	localparam int REM_W = SQ_OUT_W + 2;

	logic                  busy_q;
	logic [4:0]            cnt_q;
	logic [SQ_IN_W-1:0]    x_q;
	logic [REM_W-1:0]      rem_q;
	logic [SQ_OUT_W-1:0]   root_q;
	logic                  done_q;
	logic [REM_W-1:0]      rem_n;
	logic [REM_W-1:0]      trial;

	assign rem_n = {rem_q[REM_W-3:0], x_q[SQ_IN_W-1 -: 2]};
	assign trial = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(SQ_OUT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[SQ_IN_W-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[SQ_OUT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[SQ_OUT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ===== hw/rtl/extended_state_observer_core.sv =====
// ----------------------------------------------------------------------------
// extended_state_observer_core: third-order extended state observer
// Q16.16 observer update with fal nonlinearity on a shared multiplier and root unit.
//
//   channel   dir  beat                                        
//   sample    in   control_value, measured_output              
//   estimate  out  position, rate, disturbance estimates       
//   cfg       in   cfg_we, cfg_index, cfg_data                 
//
// Outside the linear fal region the sequencer waits on two passes of the root unit,
// one for the square root and one for the fourth root of the error.
// Reset clears the estimates to zero and loads the default gains.
// sample.ready is high only while the sequencer is idle; the last step holds
// while an earlier estimate beat is still waiting.
// ----------------------------------------------------------------------------
module extended_state_observer_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [eso_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data,
	eso_sample_if.sink                        sample,
	eso_estimate_if.source                    estimate
);
	import eso_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ERR  = 4'd1;
	localparam logic [3:0] ST_P1   = 4'd2;
	localparam logic [3:0] ST_P2   = 4'd3;
	localparam logic [3:0] ST_P3   = 4'd4;
	localparam logic [3:0] ST_P4   = 4'd5;
	localparam logic [3:0] ST_L1   = 4'd6;
	localparam logic [3:0] ST_L2   = 4'd7;
	localparam logic [3:0] ST_R2   = 4'd8;
	localparam logic [3:0] ST_R4   = 4'd9;
	localparam logic [3:0] ST_G1   = 4'd10;
	localparam logic [3:0] ST_G2   = 4'd11;
	localparam logic [3:0] ST_G3   = 4'd12;

	logic [16:0]        h_q;
	logic [31:0]        b0_q, g1_q, g2_q, g3_q;
	logic [30:0]        isc_h_q, isc_tq_q;

	logic [3:0]         state_q;
	logic signed [31:0] z0_q, z1_q, z2_q;
	logic signed [31:0] u_q, y_q;
	logic signed [32:0] e_q;
	logic signed [31:0] drive_q;
	logic signed [OPND_W-1:0] fe_q, fe1_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [31:0] n0_q, n1_q;
	logic               ovalid_q;
	estimate_t          odata_q;

	logic signed [OPND_W-1:0] ma, mb;
	logic signed [MRES_W-1:0] mres;
	logic signed [ACC_W-1:0]  mres_x;
	logic [32:0]              e_mag;
	logic                     sq_start, sq_done;
	logic [SQ_IN_W-1:0]       sq_x;
	logic [SQ_OUT_W-1:0]      sq_root;
	logic signed [OPND_W-1:0] root_s;

	eso_mul u_mul (.clk(clk), .a(ma), .b(mb), .res(mres));

	eso_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .x(sq_x),
		.done(sq_done), .root(sq_root)
	);

	assign mres_x = ACC_W'(mres);
	assign e_mag  = e_q[32] ? 33'(-e_q) : e_q[32:0];
	assign root_s = e_q[32] ? -$signed(OPND_W'(sq_root)) : $signed(OPND_W'(sq_root));

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_ERR: begin
				ma = OPND_W'($signed(b0_q));
				mb = OPND_W'(u_q);
			end
			ST_P1: begin
				ma = OPND_W'($signed(g1_q));
				mb = OPND_W'(e_q);
			end
			ST_P2: begin
				ma = OPND_W'($signed({1'b0, h_q}));
				mb = OPND_W'(z1_q);
			end
			ST_P3: begin
				ma = OPND_W'($signed({1'b0, h_q}));
				mb = OPND_W'(z2_q) + OPND_W'(drive_q);
			end
			ST_P4: begin
				ma = OPND_W'(e_q);
				mb = OPND_W'($signed({1'b0, isc_h_q}));
			end
			ST_L1: begin
				ma = OPND_W'(e_q);
				mb = OPND_W'($signed({1'b0, isc_tq_q}));
			end
			ST_G1: begin
				ma = OPND_W'($signed(g2_q));
				mb = fe_q;
			end
			ST_G2, ST_G3: begin
				ma = OPND_W'($signed(g3_q));
				mb = fe1_q;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		sq_start = 1'b0;
		sq_x     = '0;
		if (state_q == ST_P4 && e_mag > 33'(h_q)) begin
			sq_start = 1'b1;
			sq_x     = SQ_IN_W'({e_mag, 16'd0});
		end else if (state_q == ST_R2 && sq_done) begin
			sq_start = 1'b1;
			sq_x     = SQ_IN_W'({sq_root, 16'd0});
		end
	end

	assign sample.ready   = (state_q == ST_IDLE);
	assign estimate.valid = ovalid_q;
	assign estimate.data  = odata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q      <= 17'd655;
			b0_q     <= 32'd65536;
			g1_q     <= 32'd65536;
			g2_q     <= 32'd2184533;
			g3_q     <= 32'd20480000;
			isc_h_q  <= 31'd655360;
			isc_tq_q <= 31'd2072430;
			state_q  <= ST_IDLE;
			z0_q     <= '0;
			z1_q     <= '0;
			z2_q     <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PERIOD: h_q      <= cfg_data[16:0];
					REG_B0:     b0_q     <= cfg_data;
					REG_G1:     g1_q     <= cfg_data;
					REG_G2:     g2_q     <= cfg_data;
					REG_G3:     g3_q     <= cfg_data;
					REG_ISC_H:  isc_h_q  <= cfg_data[30:0];
					REG_ISC_TQ: isc_tq_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (ovalid_q && estimate.ready && state_q != ST_G3)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (sample.valid) state_q <= ST_ERR;
				ST_ERR:  state_q <= ST_P1;
				ST_P1:   state_q <= ST_P2;
				ST_P2:   state_q <= ST_P3;
				ST_P3:   state_q <= ST_P4;
				ST_P4:   state_q <= (e_mag > 33'(h_q)) ? ST_R2 : ST_L1;
				ST_L1:   state_q <= ST_L2;
				ST_L2:   state_q <= ST_G1;
				ST_R2:   if (sq_done) state_q <= ST_R4;
				ST_R4:   if (sq_done) state_q <= ST_G1;
				ST_G1:   state_q <= ST_G2;
				ST_G2:   state_q <= ST_G3;
				ST_G3: begin
					if (!ovalid_q || estimate.ready) begin
						z0_q     <= n0_q;
						z1_q     <= n1_q;
						z2_q     <= sat32(ACC_W'(z2_q) - mres_x);
						ovalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				u_q <= sample.data.control_value;
				y_q <= sample.data.measured_output;
			end
			ST_ERR:  e_q     <= 33'(z0_q) - 33'(y_q);
			ST_P1:   drive_q <= sat32(mres_x);
			ST_P2:   acc_q   <= ACC_W'(z0_q) - mres_x;
			ST_P3:   n0_q    <= sat32(acc_q + mres_x);
			ST_P4:   acc_q   <= ACC_W'(z1_q) + mres_x;
			ST_L1:   fe_q    <= OPND_W'(mres);
			ST_L2:   fe1_q   <= OPND_W'(mres);
			ST_R2:   if (sq_done) fe_q <= root_s;
			ST_R4:   if (sq_done) fe1_q <= root_s;
			ST_G2:   n1_q    <= sat32(acc_q - mres_x);
			ST_G3: begin
				if (!ovalid_q || estimate.ready) begin
					odata_q.position_estimate    <= n0_q;
					odata_q.rate_estimate        <= n1_q;
					odata_q.disturbance_estimate <= sat32(ACC_W'(z2_q) - mres_x);
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: extended state observer core testbench
// Drives samples through the valid/ready channel under random gaps and stalls,
// recomputes each Q16.16 observer update from an independent fixed-point model
// and compares every estimate beat field by field, over several gain settings.
// ----------------------------------------------------------------------------
module tb;
	import eso_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	eso_sample_if   smp ();
	eso_estimate_if est ();

	extended_state_observer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (smp),
		.estimate  (est)
	);

	// observer model state and register copy
	longint unsigned obs_reg [7];
	longint          obs_z0, obs_z1, obs_z2;

	sample_t   sample_queue [$];
	estimate_t expected_estimates [$];
	int        error_count;
	int        beats_out;
	bit        in_fire, out_fire;
	int        tx_gap, rx_gap, hold_cnt, idle_cycles;
	bit        tx_burst, rx_burst, hold_done;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic longint unsigned mag_of(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint q_mul(longint a, longint b);
		longint unsigned p;
		longint unsigned r;
		p = mag_of(a) * mag_of(b);
		r = (p + 64'd32768) >> FRAC_BITS;
		return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint fal_term(longint e, longint unsigned lin_scale, bit quarter);
		longint unsigned m;
		longint unsigned root;
		m = mag_of(e);
		if (m <= obs_reg[REG_PERIOD])
			return q_mul(e, longint'(lin_scale));
		root = int_sqrt(m << FRAC_BITS);
		if (quarter)
			root = int_sqrt(root << FRAC_BITS);
		return (e < 0) ? -longint'(root) : longint'(root);
	endfunction

	function automatic longint reg_signed(longint unsigned r);
		return longint'($signed(r[31:0]));
	endfunction

	function automatic estimate_t observer_update(sample_t s);
		longint    e, fe, fe1, drive, h;
		estimate_t r;
		h = longint'(obs_reg[REG_PERIOD]);
		e = obs_z0 - longint'(s.measured_output);
		fe = fal_term(e, obs_reg[REG_ISC_H], 1'b0);
		fe1 = fal_term(e, obs_reg[REG_ISC_TQ], 1'b1);
		drive = clamp32(q_mul(reg_signed(obs_reg[REG_B0]), longint'(s.control_value)));
		r.position_estimate = 32'(clamp32(obs_z0 + q_mul(h, obs_z1)
			- q_mul(reg_signed(obs_reg[REG_G1]), e)));
		r.rate_estimate = 32'(clamp32(obs_z1 + q_mul(h, obs_z2 + drive)
			- q_mul(reg_signed(obs_reg[REG_G2]), fe)));
		r.disturbance_estimate = 32'(clamp32(obs_z2
			- q_mul(reg_signed(obs_reg[REG_G3]), fe1)));
		obs_z0 = longint'(r.position_estimate);
		obs_z1 = longint'(r.rate_estimate);
		obs_z2 = longint'(r.disturbance_estimate);
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	// monitor: predict on input beats, check on estimate beats
	always @(posedge clk) begin
		estimate_t want;
		in_fire <= smp.valid && smp.ready;
		out_fire <= est.valid && est.ready;
		if (arst_n) begin
			if (smp.valid && smp.ready)
				expected_estimates.push_back(observer_update(smp.data));
			if (est.valid && est.ready) begin
				beats_out++;
				if (expected_estimates.size() == 0) begin
					report("unexpected beat", est.data.position_estimate, 32'h0);
				end else begin
					want = expected_estimates.pop_front();
					if (est.data.position_estimate !== want.position_estimate)
						report("position", est.data.position_estimate,
							want.position_estimate);
					if (est.data.rate_estimate !== want.rate_estimate)
						report("rate", est.data.rate_estimate, want.rate_estimate);
					if (est.data.disturbance_estimate !== want.disturbance_estimate)
						report("disturbance", est.data.disturbance_estimate,
							want.disturbance_estimate);
				end
			end
			if ((smp.valid && smp.ready) || (est.valid && est.ready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	// sample driver
	always @(negedge clk) begin
		bit nxt;
		if (arst_n) begin
			nxt = smp.valid && !in_fire;
			if (!nxt) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (sample_queue.size() > 0) begin
					smp.data <= sample_queue.pop_front();
					nxt = 1'b1;
					if ($urandom_range(0, 40) == 0)
						tx_burst = !tx_burst;
					tx_gap = tx_burst ? 0 : $urandom_range(0, 14);
				end
			end
			smp.valid <= nxt;
		end
	end

	// estimate receiver, with one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (est.ready && out_fire) begin
				if ($urandom_range(0, 40) == 0)
					rx_burst = !rx_burst;
				rx_gap = rx_burst ? 0 : $urandom_range(0, 14);
			end
			if (!hold_done && beats_out >= 300) begin
				hold_done = 1'b1;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				est.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				est.ready <= 1'b0;
			end else begin
				est.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		longint unsigned mask [7] = '{64'h1FFFF, 64'hFFFFFFFF, 64'hFFFFFFFF, 64'hFFFFFFFF,
			64'hFFFFFFFF, 64'h7FFFFFFF, 64'h7FFFFFFF};
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx != REG_UNUSED)
			obs_reg[idx] = longint'(value) & mask[idx];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (sample_queue.size() != 0 || smp.valid || expected_estimates.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// one sample whose error sits at a chosen offset from the position estimate
	task automatic offset_sample(longint offs);
		sample_t s;
		s.control_value = $urandom;
		s.measured_output = 32'(clamp32(obs_z0 - offs));
		sample_queue.push_back(s);
		wait_idle();
	endtask

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'(-$urandom_range(0, 200000));
			default: return $urandom_range(0, 3000000);
		endcase
	endfunction

	function automatic logic [31:0] pick_period();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'h1;
			2: return 32'h10000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom_range(1, 4000);
		endcase
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		case ($urandom_range(0, 3))
			0: begin
				s.control_value = $urandom;
				s.measured_output = $urandom;
			end
			1: begin
				s.control_value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
				s.measured_output = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			end
			default: begin
				s.control_value = 32'($signed($urandom_range(0, 262144)) - 131072);
				s.measured_output = 32'(obs_z0 + $signed($urandom_range(0, 4000)) - 2000);
			end
		endcase
		return s;
	endfunction

	initial begin
		sample_t s;
		int      i;
		int      p;
		smp.valid = 1'b0;
		smp.data = '0;
		est.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PERIOD;
		cfg_data = '0;
		error_count = 0;
		beats_out = 0;
		tx_gap = 0;
		rx_gap = 0;
		hold_cnt = 0;
		idle_cycles = 0;
		tx_burst = 1'b0;
		rx_burst = 1'b1;
		hold_done = 1'b0;
		obs_reg = '{64'd655, 64'd65536, 64'd65536, 64'd2184533, 64'd20480000,
			64'd655360, 64'd2072430};
		obs_z0 = 0;
		obs_z1 = 0;
		obs_z2 = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fal boundaries at reset gains, then field extremes
		offset_sample(0);
		offset_sample(655);
		offset_sample(-655);
		offset_sample(656);
		offset_sample(-656);
		foreach (obs_reg[k]) begin
			s.control_value = (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
			s.measured_output = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			sample_queue.push_back(s);
		end
		wait_idle();
		write_reg(REG_PERIOD, 32'h0);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		offset_sample(0);
		offset_sample(1);
		offset_sample(-1);
		write_reg(REG_PERIOD, 32'h10000);
		write_reg(REG_ISC_H, 32'hFFFF_FFFF);
		write_reg(REG_ISC_TQ, 32'h7FFF_FFFF);
		write_reg(REG_G2, 32'h8000_0000);
		write_reg(REG_G3, 32'h7FFF_FFFF);
		offset_sample(65536);
		offset_sample(-65536);
		offset_sample(65537);
		offset_sample(-65537);

		for (p = 0; p < 6; p++) begin
			write_reg(REG_PERIOD, pick_period());
			write_reg(REG_B0, pick_gain());
			write_reg(REG_G1, (p == 1) ? 32'h8000_0000 : pick_gain());
			write_reg(REG_G2, pick_gain());
			write_reg(REG_G3, pick_gain());
			write_reg(REG_ISC_H, (p == 2) ? 32'h0 : $urandom);
			write_reg(REG_ISC_TQ, (p == 3) ? 32'h7FFF_FFFF : $urandom);
			for (i = 0; i < 155; i++)
				sample_queue.push_back(random_sample());
			wait_idle();
		end

		if (error_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/eso_pkg.sv
hw/rtl/eso_if.sv
hw/rtl/eso_mul.sv
hw/rtl/eso_sqrt.sv
hw/rtl/extended_state_observer_core.sv
verif/tb.sv
